// ===== rtl/alt_pkg.sv =====
// Types, codes and character helpers for the assembly line tokenizer.
// No dependencies; used by alt_scan, alt_outq and the top level.
`default_nettype none
package alt_pkg;

    typedef enum logic [3:0] {
        M_IDLE, M_DEC, M_HEX, M_BIN, M_PCT, M_ID, M_DIR, M_REM,
        M_STR, M_CHOPEN, M_CHCLOSE, M_DG, M_SKIP
    } t_mode;

    localparam logic [4:0] K_EOL   = 5'd0;
    localparam logic [4:0] K_ERR   = 5'd1;
    localparam logic [4:0] K_NUM   = 5'd2;
    localparam logic [4:0] K_ID    = 5'd3;
    localparam logic [4:0] K_DIR   = 5'd4;
    localparam logic [4:0] K_STR   = 5'd5;
    localparam logic [4:0] K_REM   = 5'd6;
    localparam logic [4:0] K_DG0   = 5'd7;
    localparam logic [4:0] K_CHR   = 5'd16;
    localparam logic [4:0] K_SBYTE = 5'd17;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // one token as produced by the scanner
    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  code;
        logic [63:0] value;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
    } t_tok;

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == 8'h5F;
    endfunction

    function automatic logic is_dg_start(input logic [7:0] c);
        return c == 8'h3C || c == 8'h7E || c == 8'h3E || c == 8'h26 || c == 8'h7C ||
               c == 8'h3D || c == 8'h21;
    endfunction

    // returns {valid, 4-bit value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (is_digit(c)) r = {1'b1, c[3:0]};
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    // returns {valid, byte}
    function automatic logic [8:0] decode_escape(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        case (c)
            8'h61: r = {1'b1, 8'd7};
            8'h62: r = {1'b1, 8'd8};
            8'h66: r = {1'b1, 8'd12};
            8'h6E: r = {1'b1, 8'd10};
            8'h72: r = {1'b1, 8'd13};
            8'h74: r = {1'b1, 8'd9};
            8'h76: r = {1'b1, 8'd11};
            8'h5C: r = {1'b1, 8'd92};
            8'h27: r = {1'b1, 8'd39};
            8'h22: r = {1'b1, 8'd34};
            8'h30: r = {1'b1, 8'd0};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // returns {hit, index 0..8}
    function automatic logic [4:0] dg_match(input logic [7:0] h, input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if      (h == 8'h3E && c == 8'h3E) r = {1'b1, 4'd0};
        else if (h == 8'h7E && c == 8'h3E) r = {1'b1, 4'd1};
        else if (h == 8'h3C && c == 8'h3C) r = {1'b1, 4'd2};
        else if (h == 8'h26 && c == 8'h26) r = {1'b1, 4'd3};
        else if (h == 8'h7C && c == 8'h7C) r = {1'b1, 4'd4};
        else if (h == 8'h3C && c == 8'h3D) r = {1'b1, 4'd5};
        else if (h == 8'h3E && c == 8'h3D) r = {1'b1, 4'd6};
        else if (h == 8'h3D && c == 8'h3D) r = {1'b1, 4'd7};
        else if (h == 8'h21 && c == 8'h3D) r = {1'b1, 4'd8};
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/alt_accum.sv =====
// Saturating digit accumulator: acc * base + d, clamped at all ones.
// Depends on nothing; base is 2, 10 or 16 (shift/add only).
`default_nettype none
module alt_accum #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic [VALUE_BITS-1:0] i_acc,
    input  wire logic [1:0]            i_base_sel,   // 0 bin, 1 dec, 2 hex
    input  wire logic [3:0]            i_digit,
    output logic      [VALUE_BITS-1:0] o_acc
);
    logic [VALUE_BITS+4:0] w_prod;
    logic [VALUE_BITS+4:0] w_sum;

    always_comb begin
        case (i_base_sel)
            2'd0:    w_prod = {5'd0, i_acc} << 1;
            2'd1:    w_prod = ({5'd0, i_acc} << 3) + ({5'd0, i_acc} << 1);
            default: w_prod = {5'd0, i_acc} << 4;
        endcase
        w_sum = w_prod + {{(VALUE_BITS+1){1'b0}}, i_digit};
        // overflow past the value width means saturate
        if (w_sum[VALUE_BITS+4:VALUE_BITS] != 5'd0) o_acc = {VALUE_BITS{1'b1}};
        else o_acc = w_sum[VALUE_BITS-1:0];
    end
endmodule
`default_nettype wire

// ===== rtl/alt_scan.sv =====
// Scanner core: registered state plus the single-pass next-state logic.
// Uses alt_pkg and alt_accum; produces up to two tokens per character.
`default_nettype none
module alt_scan #(
    parameter int COLUMN_BITS = 12,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_step,
    input  wire logic [7:0]   i_char,
    output alt_pkg::t_tok     o_tok0,
    output alt_pkg::t_tok     o_tok1,
    output logic [1:0]        o_count
);
    import alt_pkg::*;

    localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};

    t_mode                  r_mode, n_mode;
    logic [VALUE_BITS-1:0]  r_acc, n_acc;
    logic [COLUMN_BITS-1:0] r_start, n_start;
    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic [15:0]            r_line, n_line;
    logic [7:0]             r_held, n_held;
    logic                   r_esc, n_esc;

    logic [VALUE_BITS-1:0]  w_acc_next;
    logic [1:0]             w_base;
    logic [3:0]             w_digit;
    logic [4:0]             w_hex;
    logic [8:0]             w_escv;
    logic [4:0]             w_dg;
    logic [15:0]            w_col16, w_start16, w_len;
    t_tok                   w_tok [2];
    logic [1:0]             w_n;
    logic                   w_restart;

    alt_accum #(.VALUE_BITS(VALUE_BITS)) u_accum (
        .i_acc(r_acc), .i_base_sel(w_base), .i_digit(w_digit), .o_acc(w_acc_next)
    );

    always_comb begin
        w_hex    = hex_val(i_char);
        w_escv   = decode_escape(i_char);
        w_dg     = dg_match(r_held, i_char);
        w_col16  = 16'(r_col);
        w_start16 = 16'(r_start);
        w_len    = w_col16 - w_start16;
        w_base   = (r_mode == M_HEX) ? 2'd2 : (r_mode == M_DEC) ? 2'd1 : 2'd0;
        w_digit  = (r_mode == M_HEX) ? w_hex[3:0] : i_char[3:0];
    end

    // token constructor
    function automatic t_tok mk(input logic [4:0] k, input logic [7:0] c,
                                input logic [63:0] v, input logic [15:0] s,
                                input logic [15:0] l, input logic [15:0] ln);
        t_tok t;
        t.kind = k; t.code = c; t.value = v; t.start = s; t.len = l; t.line = ln;
        return t;
    endfunction

    always_comb begin
        n_mode  = r_mode;
        n_acc   = r_acc;
        n_start = r_start;
        n_col   = r_col;
        n_line  = r_line;
        n_held  = r_held;
        n_esc   = r_esc;
        w_tok[0] = '0;
        w_tok[1] = '0;
        w_n      = 2'd0;
        w_restart = 1'b0;

        if (i_char == 8'd0) begin
            // flush then eol
            unique case (r_mode)
                M_DEC, M_HEX, M_BIN: begin
                    w_tok[0] = mk(K_NUM, 8'd0, 64'(r_acc), w_start16, w_len, r_line);
                    w_n = 2'd1;
                end
                M_PCT: begin
                    w_tok[0] = mk(K_CHR, CH_PCT, 64'd0, w_start16, 16'd1, r_line);
                    w_n = 2'd1;
                end
                M_ID: begin
                    w_tok[0] = mk(K_ID, 8'd0, 64'd0, w_start16, w_len, r_line);
                    w_n = 2'd1;
                end
                M_DIR: begin
                    w_tok[0] = mk(K_DIR, 8'd0, 64'd0, w_start16, w_len, r_line);
                    w_n = 2'd1;
                end
                M_REM: begin
                    w_tok[0] = mk(K_REM, 8'd0, 64'd0, w_start16, w_len, r_line);
                    w_n = 2'd1;
                end
                M_STR, M_CHOPEN, M_CHCLOSE: begin
                    w_tok[0] = mk(K_ERR, 8'd0, 64'd0, w_start16, 16'd0, r_line);
                    w_n = 2'd1;
                end
                M_DG: begin
                    w_tok[0] = mk(K_CHR, r_held, 64'd0, w_start16, 16'd1, r_line);
                    w_n = 2'd1;
                end
                default: w_n = 2'd0;
            endcase
            w_tok[w_n[0]] = mk(K_EOL, 8'd0, 64'd0, w_col16, 16'd0, r_line);
            w_n = w_n + 2'd1;
            n_mode = M_IDLE;
            n_acc  = '0;
            n_held = 8'd0;
            n_esc  = 1'b0;
            n_col  = COLUMN_BITS'(1);
            if (r_line != 16'hFFFF) n_line = r_line + 16'd1;
        end else begin
            unique case (r_mode)
                M_DEC: begin
                    if (is_digit(i_char)) n_acc = w_acc_next;
                    else begin
                        w_tok[0] = mk(K_NUM, 8'd0, 64'(r_acc), w_start16, w_len, r_line);
                        w_n = 2'd1; w_restart = 1'b1;
                    end
                end
                M_HEX: begin
                    if (w_hex[4]) n_acc = w_acc_next;
                    else begin
                        w_tok[0] = mk(K_NUM, 8'd0, 64'(r_acc), w_start16, w_len, r_line);
                        w_n = 2'd1; w_restart = 1'b1;
                    end
                end
                M_PCT, M_BIN: begin
                    if (i_char == 8'h30 || i_char == 8'h31) begin
                        n_acc = (r_mode == M_PCT) ? VALUE_BITS'(i_char[0]) : w_acc_next;
                        n_mode = M_BIN;
                    end else begin
                        if (r_mode == M_PCT)
                            w_tok[0] = mk(K_CHR, CH_PCT, 64'd0, w_start16, 16'd1, r_line);
                        else
                            w_tok[0] = mk(K_NUM, 8'd0, 64'(r_acc), w_start16, w_len,
                                          r_line);
                        w_n = 2'd1; w_restart = 1'b1;
                    end
                end
                M_ID, M_DIR: begin
                    if (!is_word(i_char)) begin
                        w_tok[0] = mk((r_mode == M_ID) ? K_ID : K_DIR, 8'd0, 64'd0,
                                      w_start16, w_len, r_line);
                        w_n = 2'd1; w_restart = 1'b1;
                    end
                end
                M_STR: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (w_escv[8]) begin
                            w_tok[0] = mk(K_SBYTE, w_escv[7:0], 64'd0, w_col16 - 16'd1,
                                          16'd2, r_line);
                        end else begin
                            w_tok[0] = mk(K_ERR, 8'd0, 64'd0, w_start16, 16'd0, r_line);
                            n_mode = M_SKIP;
                        end
                        w_n = 2'd1;
                    end else if (i_char == CH_DQUOTE) begin
                        w_tok[0] = mk(K_STR, 8'd0, 64'd0, w_start16, w_len + 16'd1, r_line);
                        w_n = 2'd1; n_mode = M_IDLE;
                    end else if (i_char == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else begin
                        w_tok[0] = mk(K_SBYTE, i_char, 64'd0, w_col16, 16'd1, r_line);
                        w_n = 2'd1;
                    end
                end
                M_CHOPEN: begin
                    if (r_esc) begin
                        n_esc = 1'b0;
                        if (w_escv[8]) begin
                            n_acc = VALUE_BITS'(w_escv[7:0]); n_mode = M_CHCLOSE;
                        end else begin
                            w_tok[0] = mk(K_ERR, 8'd0, 64'd0, w_start16, 16'd0, r_line);
                            w_n = 2'd1; n_mode = M_SKIP;
                        end
                    end else if (i_char == CH_BSLASH) begin
                        n_esc = 1'b1;
                    end else begin
                        n_acc = VALUE_BITS'(i_char); n_mode = M_CHCLOSE;
                    end
                end
                M_CHCLOSE: begin
                    if (i_char == CH_SQUOTE)
                        w_tok[0] = mk(K_NUM, 8'd0, 64'(r_acc), w_start16, w_len + 16'd1,
                                      r_line);
                    else
                        w_tok[0] = mk(K_ERR, 8'd0, 64'd0, w_start16, 16'd0, r_line);
                    w_n = 2'd1;
                    n_mode = (i_char == CH_SQUOTE) ? M_IDLE : M_SKIP;
                    n_esc = 1'b0;
                end
                M_DG: begin
                    if (w_dg[4]) begin
                        w_tok[0] = mk(K_DG0 + {1'b0, w_dg[3:0]}, 8'd0, 64'd0, w_start16,
                                      16'd2, r_line);
                        w_n = 2'd1; n_mode = M_IDLE;
                    end else begin
                        w_tok[0] = mk(K_CHR, r_held, 64'd0, w_start16, 16'd1, r_line);
                        w_n = 2'd1; w_restart = 1'b1;
                    end
                end
                M_REM, M_SKIP: ;
                default: w_restart = 1'b1;
            endcase

            // start a new token with this character
            if (w_restart) begin
                n_mode = M_IDLE;
                n_acc  = '0;
                n_esc  = 1'b0;
                if (!is_space(i_char)) begin
                    n_start = r_col;
                    if (i_char == CH_DQUOTE) n_mode = M_STR;
                    else if (i_char == CH_SQUOTE) n_mode = M_CHOPEN;
                    else if (is_digit(i_char)) begin
                        n_mode = M_DEC; n_acc = VALUE_BITS'(i_char[3:0]);
                    end
                    else if (i_char == CH_DOLLAR) n_mode = M_HEX;
                    else if (i_char == CH_PCT) n_mode = M_PCT;
                    else if (i_char == CH_AT) n_mode = M_DIR;
                    else if (i_char == CH_SEMI) n_mode = M_REM;
                    else if (is_alpha(i_char) || i_char == 8'h5F) n_mode = M_ID;
                    else if (is_dg_start(i_char)) begin
                        n_mode = M_DG; n_held = i_char;
                    end else begin
                        w_tok[w_n[0]] = mk(K_CHR, i_char, 64'd0, w_col16, 16'd1, r_line);
                        w_n = w_n + 2'd1;
                    end
                end
            end
            if (r_col != COL_MAX) n_col = r_col + COLUMN_BITS'(1);
        end
    end

    assign o_tok0  = w_tok[0];
    assign o_tok1  = w_tok[1];
    assign o_count = w_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_acc   <= '0;
            r_start <= '0;
            r_col   <= COLUMN_BITS'(1);
            r_line  <= 16'd1;
            r_held  <= 8'd0;
            r_esc   <= 1'b0;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_acc   <= n_acc;
            r_start <= n_start;
            r_col   <= n_col;
            r_line  <= n_line;
            r_held  <= n_held;
            r_esc   <= n_esc;
        end
    end

    property p_col_nonzero;
        @(posedge i_clk) disable iff (!i_rst_n) r_col != '0;
    endproperty
    a_col_nonzero: assert property (p_col_nonzero) else $error("column count hit zero");

    property p_line_nonzero;
        @(posedge i_clk) disable iff (!i_rst_n) r_line != 16'd0;
    endproperty
    a_line_nonzero: assert property (p_line_nonzero) else $error("line count hit zero");

    property p_eol_resets_col;
        @(posedge i_clk) disable iff (!i_rst_n)
            i_step && i_char == 8'd0 |=> r_col == COLUMN_BITS'(1) && r_mode == M_IDLE;
    endproperty
    a_eol_resets_col: assert property (p_eol_resets_col) else $error("eol did not reset");

    property p_esc_only_in_lit;
        @(posedge i_clk) disable iff (!i_rst_n)
            r_esc |-> r_mode == M_STR || r_mode == M_CHOPEN;
    endproperty
    a_esc_only_in_lit: assert property (p_esc_only_in_lit) else $error("stray escape");
endmodule
`default_nettype wire

// ===== rtl/alt_outq.sv =====
// Two-entry result queue that serializes the scanner's token pair.
// Uses alt_pkg; accepts input only once queued results drain.
`default_nettype none
module alt_outq (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  alt_pkg::t_tok i_tok0,
    input  alt_pkg::t_tok i_tok1,
    input  wire logic [1:0] i_count,
    input  wire logic     i_pop,
    output logic          o_room,
    output logic          o_valid,
    output alt_pkg::t_tok o_tok,
    output logic          o_last
);
    import alt_pkg::*;

    t_tok       r_q [2];
    logic [1:0] r_last;
    logic [1:0] r_cnt;
    logic [1:0] w_after;

    assign o_valid = r_cnt != 2'd0;
    assign o_tok   = r_q[0];
    assign o_last  = r_last[0];
    assign w_after = r_cnt - {1'b0, i_pop};
    // accept only when the queue is empty after any pop
    assign o_room  = w_after == 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= w_after + (i_push ? i_count : 2'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop && r_cnt == 2'd2) begin
            r_q[0]    <= r_q[1];
            r_last[0] <= r_last[1];
        end
        if (i_push) begin
            if (i_count == 2'd2) begin
                r_q[0] <= i_tok0; r_last[0] <= 1'b0;
                r_q[1] <= i_tok1; r_last[1] <= 1'b1;
            end else begin
                r_q[0] <= i_tok0; r_last[0] <= 1'b1;
            end
        end
    end

    property p_no_overflow;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3;
    endproperty
    a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

    property p_push_when_room;
        @(posedge i_clk) disable iff (!i_rst_n) i_push && i_count != 2'd0 |-> o_room;
    endproperty
    a_push_when_room: assert property (p_push_when_room) else $error("push without room");

    property p_single_last;
        @(posedge i_clk) disable iff (!i_rst_n) r_cnt == 2'd2 |-> !r_last[0] && r_last[1];
    endproperty
    a_single_last: assert property (p_single_last) else $error("bad last marker");
endmodule
`default_nettype wire

// ===== rtl/assembly_line_tokenizer.sv =====
// Top level of the assembly line tokenizer.
// Uses alt_pkg, alt_scan and alt_outq.
//
// Usage: one source byte per request on i_char_in (i_valid/o_stall); a zero
// byte ends the line. Tokens leave on the result channel (o_valid/i_stall)
// with kind, character, value, column, length, line and last-of-run flag.
// Each byte causes zero, one or two tokens.
// Latency: a byte's first token is offered the cycle after it is taken.
// Throughput: one byte per cycle while it yields at most one token and the
// receiver keeps up; a byte that yields two tokens occupies the single
// result port until both are taken, and the input stalls meanwhile.
// The rate is set by the two-entry result queue feeding one output port.
// Reset (synchronous, active low) returns to line 1, column 1, between
// tokens, and empties the result queue. When the receiver stalls, the
// queued tokens hold and o_stall rises until they have all been taken.
`default_nettype none
module assembly_line_tokenizer #(
    parameter int COLUMN_BITS = 12,
    parameter int VALUE_BITS  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_char_in,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_token_kind,
    output logic [7:0]       o_char_code,
    output logic [31:0]      o_number_value,
    output logic [12:0]      o_start_column,
    output logic [12:0]      o_token_length,
    output logic [15:0]      o_line_number,
    output logic             o_last_of_run
);
    import alt_pkg::*;

    t_tok       w_tok0, w_tok1, w_out;
    logic [1:0] w_count;
    logic       w_room, w_step;

    assign o_stall = !w_room;
    assign w_step  = i_valid && w_room;

    alt_scan #(.COLUMN_BITS(COLUMN_BITS), .VALUE_BITS(VALUE_BITS)) u_scan (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(w_step), .i_char(i_char_in),
        .o_tok0(w_tok0), .o_tok1(w_tok1), .o_count(w_count)
    );

    alt_outq u_outq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_step), .i_tok0(w_tok0),
        .i_tok1(w_tok1), .i_count(w_count), .i_pop(o_valid && !i_stall),
        .o_room(w_room), .o_valid(o_valid), .o_tok(w_out), .o_last(o_last_of_run)
    );

    assign o_token_kind   = w_out.kind;
    assign o_char_code    = w_out.code;
    assign o_number_value = w_out.value[31:0];
    assign o_start_column = w_out.start[12:0];
    assign o_token_length = w_out.len[12:0];
    assign o_line_number  = w_out.line;
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for assembly_line_tokenizer: source lines go in on
// the request channel, and a scoreboard class predicts the tokens that come back.
// Depends on alt_pkg and the tokenizer RTL.
`timescale 1ns / 100ps
module testbench;
    import alt_pkg::*;

    localparam int COL_MAX = 4095;
    localparam longint unsigned VAL_MAX = 64'hFFFF_FFFF;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  code;
        logic [31:0] value;
        logic [12:0] start;
        logic [12:0] len;
        logic [15:0] line;
        logic        last;
    } tok_t;

    class token_scoreboard;
        tok_t pending_tokens[$];
        tok_t step_toks[$];
        t_mode mode;
        longint unsigned acc;
        int tok_start, column, line_no;
        bit [7:0] held;
        bit esc;
        int errors;
        bit [7:0] dg_a[9] = '{8'h3E, 8'h7E, 8'h3C, 8'h26, 8'h7C, 8'h3C, 8'h3E, 8'h3D, 8'h21};
        bit [7:0] dg_b[9] = '{8'h3E, 8'h3E, 8'h3C, 8'h26, 8'h7C, 8'h3D, 8'h3D, 8'h3D, 8'h3D};

        function new();
            mode = M_IDLE; acc = 0; tok_start = 0; column = 1; line_no = 1;
            held = 0; esc = 0; errors = 0;
        endfunction

        function bit is_ws(bit [7:0] c);
            return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
        endfunction
        function bit is_dig(bit [7:0] c);
            return c >= "0" && c <= "9";
        endfunction
        function bit is_let(bit [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function int hex_digit(bit [7:0] c);
            if (is_dig(c)) return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return -1;
        endfunction

        // -1 when the escape is not recognized
        function int unescape(bit [7:0] c);
            case (c)
                "a": return 7;
                "b": return 8;
                "f": return 12;
                "n": return 10;
                "r": return 13;
                "t": return 9;
                "v": return 11;
                8'h5C: return 92;
                8'h27: return 39;
                8'h22: return 34;
                "0": return 0;
                default: return -1;
            endcase
        endfunction

        function longint unsigned grow(longint unsigned a, int base, int d);
            if (a > (VAL_MAX - d) / base) return VAL_MAX;
            return a * base + d;
        endfunction

        function void put(logic [4:0] k, int code, longint unsigned v, int st, int ln);
            tok_t t;
            if (step_toks.size() >= 2) return;
            t.kind = k; t.code = 8'(code); t.value = v[31:0];
            t.start = 13'(st); t.len = 13'(ln); t.line = 16'(line_no); t.last = 1'b0;
            step_toks.push_back(t);
        endfunction

        function void fail();
            put(K_ERR, 0, 0, tok_start, 0);
            esc = 0;
            mode = M_SKIP;
        endfunction

        function void flush();
            int ln;
            ln = column - tok_start;
            case (mode)
                M_DEC, M_HEX, M_BIN: put(K_NUM, 0, acc, tok_start, ln);
                M_PCT: put(K_CHR, CH_PCT, 0, tok_start, 1);
                M_ID: put(K_ID, 0, 0, tok_start, ln);
                M_DIR: put(K_DIR, 0, 0, tok_start, ln);
                M_REM: put(K_REM, 0, 0, tok_start, ln);
                M_STR, M_CHOPEN, M_CHCLOSE: fail();
                M_DG: put(K_CHR, held, 0, tok_start, 1);
                default: ;
            endcase
            mode = M_IDLE;
            esc = 0;
        endfunction

        function void start_token(bit [7:0] c);
            mode = M_IDLE; acc = 0; esc = 0;
            if (is_ws(c)) return;
            tok_start = column;
            if (c == CH_DQUOTE) mode = M_STR;
            else if (c == CH_SQUOTE) mode = M_CHOPEN;
            else if (is_dig(c)) begin
                mode = M_DEC; acc = c - "0";
            end
            else if (c == CH_DOLLAR) mode = M_HEX;
            else if (c == CH_PCT) mode = M_PCT;
            else if (c == CH_AT) mode = M_DIR;
            else if (c == CH_SEMI) mode = M_REM;
            else if (is_let(c) || c == "_") mode = M_ID;
            else if (c inside {"<", "~", ">", "&", "|", "=", "!"}) begin
                mode = M_DG; held = c;
            end
            else put(K_CHR, c, 0, column, 1);
        endfunction

        // predict the tokens caused by one accepted byte
        function void note_char(bit [7:0] c);
            int h, i;
            step_toks.delete();
            if (c == 0) begin
                h = column;
                flush();
                put(K_EOL, 0, 0, h, 0);
                mode = M_IDLE; acc = 0; held = 0; esc = 0; column = 1;
                if (line_no < 65535) line_no++;
            end else begin
                case (mode)
                    M_DEC:
                        if (is_dig(c)) acc = grow(acc, 10, c - "0");
                        else begin flush(); start_token(c); end
                    M_HEX: begin
                        h = hex_digit(c);
                        if (h >= 0) acc = grow(acc, 16, h);
                        else begin flush(); start_token(c); end
                    end
                    M_PCT, M_BIN:
                        if (c == "0" || c == "1") begin
                            acc = (mode == M_PCT) ? c - "0" : grow(acc, 2, c - "0");
                            mode = M_BIN;
                        end else begin flush(); start_token(c); end
                    M_ID, M_DIR:
                        if (!(is_let(c) || is_dig(c) || c == "_")) begin
                            flush(); start_token(c);
                        end
                    M_STR:
                        if (esc) begin
                            esc = 0;
                            h = unescape(c);
                            if (h >= 0) put(K_SBYTE, h, 0, column - 1, 2);
                            else fail();
                        end else if (c == CH_DQUOTE) begin
                            put(K_STR, 0, 0, tok_start, column - tok_start + 1);
                            mode = M_IDLE;
                        end else if (c == CH_BSLASH) esc = 1;
                        else put(K_SBYTE, c, 0, column, 1);
                    M_CHOPEN:
                        if (esc) begin
                            esc = 0;
                            h = unescape(c);
                            if (h >= 0) begin acc = h; mode = M_CHCLOSE; end
                            else fail();
                        end else if (c == CH_BSLASH) esc = 1;
                        else begin acc = c; mode = M_CHCLOSE; end
                    M_CHCLOSE:
                        if (c == CH_SQUOTE) begin
                            put(K_NUM, 0, acc, tok_start, column - tok_start + 1);
                            mode = M_IDLE;
                        end else fail();
                    M_DG: begin
                        for (i = 0; i < 9; i++)
                            if (dg_a[i] == held && dg_b[i] == c) break;
                        if (i < 9) begin
                            put(5'(K_DG0 + i), 0, 0, tok_start, 2);
                            mode = M_IDLE;
                        end else begin flush(); start_token(c); end
                    end
                    M_REM, M_SKIP: ;
                    default: start_token(c);
                endcase
                if (column < COL_MAX) column++;
            end
            if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
            foreach (step_toks[k]) pending_tokens.push_back(step_toks[k]);
        endfunction

        function void check_token(tok_t got);
            tok_t e;
            if (pending_tokens.size() == 0) begin
                errors++;
                $display("%0t: unexpected token, actual %p", $realtime, got);
                return;
            end
            e = pending_tokens.pop_front();
            if (got !== e) begin
                errors++;
                if (got.kind !== e.kind) $display("%0t: kind expected %0d actual %0d",
                    $realtime, e.kind, got.kind);
                if (got.code !== e.code) $display("%0t: char expected %0d actual %0d",
                    $realtime, e.code, got.code);
                if (got.value !== e.value) $display("%0t: value expected %0d actual %0d",
                    $realtime, e.value, got.value);
                if (got.start !== e.start) $display("%0t: column expected %0d actual %0d",
                    $realtime, e.start, got.start);
                if (got.len !== e.len) $display("%0t: length expected %0d actual %0d",
                    $realtime, e.len, got.len);
                if (got.line !== e.line) $display("%0t: line expected %0d actual %0d",
                    $realtime, e.line, got.line);
                if (got.last !== e.last) $display("%0t: last expected %0d actual %0d",
                    $realtime, e.last, got.last);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic [7:0] i_char_in = 8'd0;
    logic i_stall = 1'b0;
    logic o_stall, o_valid, o_last_of_run;
    logic [4:0] o_token_kind;
    logic [7:0] o_char_code;
    logic [31:0] o_number_value;
    logic [12:0] o_start_column, o_token_length;
    logic [15:0] o_line_number;

    assembly_line_tokenizer uut (.*);

    always #5 i_clk = ~i_clk;

    token_scoreboard sb = new();
    bit idle_on = 1'b0;
    int rx_left = 0;
    int cycles = 0;
    int sent = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("assembly_line_tokenizer regression: fail");
            $finish;
        end
    end

    // result side: check taken tokens, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_token({o_token_kind, o_char_code, o_number_value, o_start_column,
                            o_token_length, o_line_number, o_last_of_run});
        if (rx_left == 0) begin
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                rx_left <= $urandom_range(1, 10);
            end else i_stall <= 1'b0;
        end else begin
            rx_left <= rx_left - 1;
            if (rx_left == 1) i_stall <= 1'b0;
        end
    end

    task automatic send_char(bit [7:0] c);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_char_in <= c;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_char(c);
        sent++;
    endtask

    task automatic send_line(string s);
        for (int k = 0; k < s.len(); k++) send_char(s[k]);
        send_char(8'd0);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic bit [7:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // one random lexeme, mostly well formed
    function automatic string fragment();
        string s, hx, wc, esc_ok;
        int n;
        hx = "0123456789abcdefABCDEF";
        wc = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        esc_ok = "abfnrtv\\'\"0";
        s = "";
        case ($urandom_range(0, 11))
            0: begin
                n = $urandom_range(1, 12);
                repeat (n) s = {s, string'(pick("0123456789"))};
            end
            1: begin
                s = "$";
                n = $urandom_range(0, 10);
                repeat (n) s = {s, string'(pick(hx))};
            end
            2: begin
                s = "%";
                n = $urandom_range(0, 36);
                repeat (n) s = {s, string'(pick("01"))};
            end
            3: begin
                s = string'(pick({wc.substr(0, 52)}));
                n = $urandom_range(0, 6);
                repeat (n) s = {s, string'(pick(wc))};
            end
            4: begin
                s = "@";
                n = $urandom_range(0, 5);
                repeat (n) s = {s, string'(pick(wc))};
            end
            5: begin
                s = ";";
                n = $urandom_range(0, 8);
                repeat (n) s = {s, string'(8'($urandom_range(1, 255)))};
            end
            6: begin
                s = "\"";
                n = $urandom_range(0, 6);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0)
                        s = {s, "\\", string'($urandom_range(0, 15) == 0 ?
                             pick("xyzq9") : pick(esc_ok))};
                    else
                        s = {s, string'(8'($urandom_range(32, 126) == 34 ? 65 :
                             $urandom_range(32, 126)))};
                end
                if ($urandom_range(0, 7) != 0) s = {s, "\""};
            end
            7: begin
                s = "'";
                if ($urandom_range(0, 2) == 0)
                    s = {s, "\\", string'($urandom_range(0, 9) == 0 ? pick("kq") :
                         pick(esc_ok))};
                else s = {s, string'(8'($urandom_range(1, 255)))};
                if ($urandom_range(0, 7) != 0) s = {s, "'"};
            end
            8: begin
                s = string'(pick("<~>&|=!"));
                s = {s, string'($urandom_range(0, 2) == 0 ? 8'($urandom_range(1, 255)) :
                     pick("<>&|=~!"))};
            end
            9: s = string'(8'($urandom_range(1, 255)));
            10: s = string'(pick("+-*/(),:#[]^?.`{}"));
            default: s = string'(pick(" \t"));
        endcase
        return s;
    endfunction

    initial begin
        string ln;
        int nfrag;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: number forms, saturation, lone prefixes, literals, operators
        send_line("99999999999 $ %2 $fF");
        send_line("'\\n' 'a' \"x\\t\" @d ;c");
        send_line(">> ~> << && || <= >= == != <a");
        send_line("\"\\q\" ok");
        send_line("'ab");
        send_char(8'd255);
        send_char(8'd0);
        drain();

        idle_on = 1'b1;
        while (sent < 700) begin
            if (sent > 350 && sent < 380) drain();
            ln = "";
            nfrag = $urandom_range(1, 6);
            repeat (nfrag) begin
                ln = {ln, fragment()};
                if ($urandom_range(0, 2) != 0)
                    ln = {ln, string'(pick(" \t\v\f\r"))};
            end
            send_line(ln);
            if (sent > 600) idle_on = 1'b0;
        end
        idle_on = 1'b0;
        send_line("end");

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_tokens.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0)
            $display("assembly_line_tokenizer regression: pass");
        else
            $display("assembly_line_tokenizer regression: fail");
        $finish;
    end
endmodule
